@@ src/fccw_pkg.sv @@
// Shared types, codes and widths for the FAT16 cluster chain walker.
`timescale 1ns / 1ps
`default_nettype none

package fccw_pkg;

	// Default sizes handed to the top level parameters.
	localparam int TABLE_ENTRIES_DEF = 65536;
	localparam int MAX_CHAIN_DEF     = 64;

	// Field widths.
	localparam int CLUSTER_W = 16;
	localparam int LEN_W     = 32;
	localparam int OFFSET_W  = 36;
	localparam int COUNT_W   = 20;
	localparam int CSIZE_W   = 21;

	// Item command codes.
	localparam logic [1:0] CMD_LOAD = 2'd0;
	localparam logic [1:0] CMD_FILE = 2'd1;
	localparam logic [1:0] CMD_DIR  = 2'd2;

	// Result status codes.
	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_TOO_LONG = 2'd1;
	localparam logic [1:0] ST_EMPTY    = 2'd2;
	localparam logic [1:0] ST_LOW      = 2'd3;

	// Configuration register indexes.
	localparam logic [2:0] REG_BYTES_PER_SECTOR    = 3'd0;
	localparam logic [2:0] REG_SECTORS_PER_CLUSTER = 3'd1;
	localparam logic [2:0] REG_RESERVED_SECTORS    = 3'd2;
	localparam logic [2:0] REG_TABLE_SECTORS       = 3'd3;
	localparam logic [2:0] REG_TABLE_COPIES        = 3'd4;
	localparam logic [2:0] REG_ROOT_ENTRY_COUNT    = 3'd5;

	// Cluster values at or above this mark end a chain.
	localparam logic [CLUSTER_W-1:0] END_MARK = 16'hFFF8;

	// Which result the output register is loaded with.
	typedef enum logic [1:0] {
		EMIT_ROOT,
		EMIT_START,
		EMIT_STEP,
		EMIT_NEXT
	} emit_kind_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic       load;
		logic       capture;
		logic       chain_init;
		logic       rd_issue;
		logic       advance;
		logic       emit;
		emit_kind_t kind;
		logic [1:0] status;
		logic       last;
	} dp_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic root_req;
		logic empty_req;
		logic start_low;
		logic out_free;
		logic end_hit;
		logic chain_full;
		logic next_low;
	} dp_stat_t;

endpackage

`default_nettype wire

@@ src/fat16_cluster_chain_walker.sv @@
// Top level of the FAT16 cluster chain walker: controller plus datapath.
// A load item is written to the table when it is accepted; loads can follow each other back to back.
// A walk item waits in a settling state for the geometry, then a dispatch state, then per
// cluster a table read and a result register load, plus an error state for a low cluster.
// Results leave through an output register; a stalled output holds the walk in place.
// Reset (arst_n low) loads the default volume configuration and empties the output; the table
// holds whatever it held and must be loaded before use.
`timescale 1ns / 1ps
`default_nettype none

module fat16_cluster_chain_walker #(
	parameter int TABLE_ENTRIES = fccw_pkg::TABLE_ENTRIES_DEF,
	parameter int MAX_CHAIN     = fccw_pkg::MAX_CHAIN_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_valid,
	output      logic        cfg_ready,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [15:0] cfg_data,
	input  wire logic        in_valid,
	output      logic        in_ready,
	input  wire logic [1:0]  command,
	input  wire logic [15:0] table_index,
	input  wire logic [15:0] table_value,
	input  wire logic [15:0] start_cluster,
	input  wire logic [31:0] file_length,
	output      logic        out_valid,
	input  wire logic        out_ready,
	output      logic [15:0] cluster_number,
	output      logic [35:0] byte_offset,
	output      logic [19:0] byte_count,
	output      logic [1:0]  status,
	output      logic        last
);
	import fccw_pkg::*;

	dp_cmd_t  dp_cmd;
	dp_stat_t dp_stat;

	// Sequencing.
	fccw_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.command  (command),
		.stat     (dp_stat),
		.cmd      (dp_cmd)
	);

	// Storage and arithmetic.
	fccw_datapath #(
		.TABLE_ENTRIES (TABLE_ENTRIES),
		.MAX_CHAIN     (MAX_CHAIN)
	) u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (dp_cmd),
		.stat           (dp_stat),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.command        (command),
		.table_index    (table_index),
		.table_value    (table_value),
		.start_cluster  (start_cluster),
		.file_length    (file_length),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.cluster_number (cluster_number),
		.byte_offset    (byte_offset),
		.byte_count     (byte_count),
		.status         (status),
		.last           (last)
	);

endmodule

`default_nettype wire

@@ src/fccw_datapath.sv @@
// Datapath: configuration, geometry, allocation table memory, chain registers, result register.
`timescale 1ns / 1ps
`default_nettype none

module fccw_datapath #(
	parameter int TABLE_ENTRIES = fccw_pkg::TABLE_ENTRIES_DEF,
	parameter int MAX_CHAIN     = fccw_pkg::MAX_CHAIN_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire fccw_pkg::dp_cmd_t              cmd,
	output      fccw_pkg::dp_stat_t             stat,
	input  wire logic                           cfg_valid,
	output      logic                           cfg_ready,
	input  wire logic [2:0]                     cfg_index,
	input  wire logic [15:0]                    cfg_data,
	input  wire logic [1:0]                     command,
	input  wire logic [15:0]                    table_index,
	input  wire logic [15:0]                    table_value,
	input  wire logic [15:0]                    start_cluster,
	input  wire logic [31:0]                    file_length,
	output      logic                           out_valid,
	input  wire logic                           out_ready,
	output      logic [15:0]                    cluster_number,
	output      logic [35:0]                    byte_offset,
	output      logic [19:0]                    byte_count,
	output      logic [1:0]                     status,
	output      logic                           last
);
	import fccw_pkg::*;

	localparam int AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam int NW = $clog2(MAX_CHAIN + 1);
	localparam logic [CSIZE_W-1:0] COUNT_MAX = 21'h0FFFFF;

	// Clamp a byte count to the result field.
	function automatic logic [COUNT_W-1:0] sat_count(input logic [CSIZE_W-1:0] v);
		logic [COUNT_W-1:0] r;
		r = (v > COUNT_MAX) ? '1 : v[COUNT_W-1:0];
		return r;
	endfunction

	// Configuration registers.
	logic [12:0] bps_q;
	logic [7:0]  spc_q;
	logic [15:0] res_q;
	logic [15:0] tsec_q;
	logic [7:0]  copies_q;
	logic [15:0] root_q;

	// Volume geometry, recomputed every cycle from the configuration.
	logic [CSIZE_W-1:0]  csize_q;
	logic [23:0]         fat_q;
	logic [24:0]         sum_q;
	logic [OFFSET_W-1:0] tstart_q;
	logic [OFFSET_W-1:0] dstart_q;

	// Walk registers.
	logic                 file_q;
	logic [CLUSTER_W-1:0] start_q;
	logic [LEN_W-1:0]     len_q;
	logic [CLUSTER_W-1:0] cur_q;
	logic [LEN_W-1:0]     bytes_left_q;
	logic [NW-1:0]        n_q;
	logic [OFFSET_W-1:0]  prod_q;
	logic [CSIZE_W-1:0]   take_q;
	logic [CLUSTER_W-1:0] rdata_q;
	logic                 oob_q;

	// Allocation table.
	logic [CLUSTER_W-1:0] mem [TABLE_ENTRIES];

	logic [CLUSTER_W-1:0] next_c;
	logic [CSIZE_W-1:0]   take_c;
	logic                 idx_ok_c;
	logic                 out_valid_q;

	assign cfg_ready = 1'b1;

	// Configuration writes; indexes past the list are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bps_q    <= 13'd512;
			spc_q    <= 8'd4;
			res_q    <= 16'd1;
			tsec_q   <= 16'd32;
			copies_q <= 8'd2;
			root_q   <= 16'd512;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_BYTES_PER_SECTOR:    bps_q    <= cfg_data[12:0];
				REG_SECTORS_PER_CLUSTER: spc_q    <= cfg_data[7:0];
				REG_RESERVED_SECTORS:    res_q    <= cfg_data;
				REG_TABLE_SECTORS:       tsec_q   <= cfg_data;
				REG_TABLE_COPIES:        copies_q <= cfg_data[7:0];
				REG_ROOT_ENTRY_COUNT:    root_q   <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// Geometry pipeline: table size, sector sum, table start and data start are registered in turn.
	always_ff @(posedge clk) begin
		csize_q  <= CSIZE_W'(bps_q * spc_q);
		fat_q    <= 24'(tsec_q * copies_q);
		sum_q    <= 25'(res_q) + 25'(fat_q);
		tstart_q <= OFFSET_W'(bps_q * sum_q);
		dstart_q <= tstart_q + OFFSET_W'({root_q, 5'b0});
	end

	// Table memory: one write for a load or one registered read per chain step.
	assign idx_ok_c = {1'b0, table_index} < 17'(TABLE_ENTRIES);

	always_ff @(posedge clk) begin
		if (cmd.load && idx_ok_c) begin
			mem[table_index[AW-1:0]] <= table_value;
		end
		if (cmd.rd_issue) begin
			rdata_q <= mem[cur_q[AW-1:0]];
		end
	end

	// Bytes taken from the current cluster.
	always_comb begin
		take_c = csize_q;
		if (file_q && (bytes_left_q < LEN_W'(csize_q))) begin
			take_c = bytes_left_q[CSIZE_W-1:0];
		end
	end

	assign next_c = oob_q ? '0 : rdata_q;

	// Item capture and chain walking registers.
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			file_q  <= (command == CMD_FILE);
			start_q <= start_cluster;
			len_q   <= file_length;
		end
		if (cmd.chain_init) begin
			cur_q        <= start_q;
			bytes_left_q <= len_q;
			n_q          <= '0;
		end
		if (cmd.rd_issue) begin
			oob_q  <= {1'b0, cur_q} >= 17'(TABLE_ENTRIES);
			prod_q <= OFFSET_W'((cur_q - 16'd2) * csize_q);
			take_q <= take_c;
			n_q    <= n_q + 1'b1;
			if (file_q) begin
				bytes_left_q <= bytes_left_q - LEN_W'(take_c);
			end
		end
		if (cmd.advance) begin
			cur_q <= next_c;
		end
	end

	// Status toward the controller.
	always_comb begin
		stat.root_req   = !file_q && (start_q == '0);
		stat.empty_req  = (file_q && (len_q == '0)) || (start_q >= END_MARK);
		stat.start_low  = start_q < 16'd2;
		stat.out_free   = !out_valid_q || out_ready;
		stat.end_hit    = (next_c >= END_MARK) || (file_q && (bytes_left_q == '0));
		stat.chain_full = n_q >= NW'(MAX_CHAIN);
		stat.next_low   = next_c < 16'd2;
	end

	// Output register; holds a result until it is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			status <= cmd.status;
			last   <= cmd.last;
			unique case (cmd.kind)
				EMIT_ROOT: begin
					cluster_number <= '0;
					byte_offset    <= tstart_q;
					byte_count     <= sat_count({root_q, 5'b0});
				end
				EMIT_START: begin
					cluster_number <= start_q;
					byte_offset    <= '0;
					byte_count     <= '0;
				end
				EMIT_STEP: begin
					cluster_number <= cur_q;
					byte_offset    <= prod_q + dstart_q;
					byte_count     <= sat_count(take_q);
				end
				EMIT_NEXT: begin
					cluster_number <= cur_q;
					byte_offset    <= '0;
					byte_count     <= '0;
				end
				default: begin
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;

endmodule

`default_nettype wire

@@ src/fccw_ctrl.sv @@
// Controller state machine sequencing loads, walk setup and chain steps.
`timescale 1ns / 1ps
`default_nettype none

module fccw_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output      logic               in_ready,
	input  wire logic [1:0]         command,
	input  wire fccw_pkg::dp_stat_t stat,
	output      fccw_pkg::dp_cmd_t  cmd
);
	import fccw_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SETTLE,
		S_DISPATCH,
		S_READ,
		S_EVAL,
		S_ERR
	} state_t;

	// Settle counter value that ends the wait for the geometry pipeline after a walk item.
	localparam logic [1:0] SETTLE_LAST = 2'd3;

	state_t     state_q;
	logic [1:0] wait_q;
	logic       accept_c;

	assign in_ready = (state_q == S_IDLE);
	assign accept_c = in_valid && in_ready;

	// Command decode from the current state and datapath status.
	always_comb begin
		cmd        = '0;
		cmd.kind   = EMIT_STEP;
		cmd.status = ST_OK;
		unique case (state_q)
			S_IDLE: begin
				cmd.load    = accept_c && (command == CMD_LOAD);
				cmd.capture = accept_c && ((command == CMD_FILE) || (command == CMD_DIR));
			end
			S_SETTLE: begin
			end
			S_DISPATCH: begin
				if (stat.root_req) begin
					cmd.emit = stat.out_free;
					cmd.kind = EMIT_ROOT;
					cmd.last = 1'b1;
				end else if (stat.empty_req) begin
					cmd.emit   = stat.out_free;
					cmd.kind   = EMIT_START;
					cmd.status = ST_EMPTY;
					cmd.last   = 1'b1;
				end else if (stat.start_low) begin
					cmd.emit   = stat.out_free;
					cmd.kind   = EMIT_START;
					cmd.status = ST_LOW;
					cmd.last   = 1'b1;
				end else begin
					cmd.chain_init = 1'b1;
				end
			end
			S_READ: begin
				cmd.rd_issue = 1'b1;
			end
			S_EVAL: begin
				cmd.emit = stat.out_free;
				cmd.kind = EMIT_STEP;
				if (stat.end_hit) begin
					cmd.last = 1'b1;
				end else if (stat.chain_full) begin
					cmd.status = ST_TOO_LONG;
					cmd.last   = 1'b1;
				end else begin
					cmd.advance = stat.out_free;
				end
			end
			S_ERR: begin
				cmd.emit   = stat.out_free;
				cmd.kind   = EMIT_NEXT;
				cmd.status = ST_LOW;
				cmd.last   = 1'b1;
			end
			default: begin
			end
		endcase
	end

	// State register and settle counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			wait_q  <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					wait_q <= '0;
					if (cmd.capture) begin
						state_q <= S_SETTLE;
					end
				end
				S_SETTLE: begin
					wait_q <= wait_q + 1'b1;
					if (wait_q == SETTLE_LAST) begin
						state_q <= S_DISPATCH;
					end
				end
				S_DISPATCH: begin
					if (cmd.chain_init) begin
						state_q <= S_READ;
					end else if (cmd.emit) begin
						state_q <= S_IDLE;
					end
				end
				S_READ: begin
					state_q <= S_EVAL;
				end
				S_EVAL: begin
					if (stat.out_free) begin
						if (stat.end_hit || stat.chain_full) begin
							state_q <= S_IDLE;
						end else if (stat.next_low) begin
							state_q <= S_ERR;
						end else begin
							state_q <= S_READ;
						end
					end
				end
				S_ERR: begin
					if (stat.out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

@@ src/fccw_checker.sv @@
// Port-level checks for the FAT16 cluster chain walker, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module fccw_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_valid,
	input wire logic        in_ready,
	input wire logic [1:0]  command,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic [15:0] cluster_number,
	input wire logic [35:0] byte_offset,
	input wire logic [19:0] byte_count,
	input wire logic [1:0]  status,
	input wire logic        last
);
	import fccw_pkg::*;

	// A stalled result holds its fields.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(cluster_number)
			&& $stable(byte_offset) && $stable(byte_count) && $stable(status) && $stable(last))
		else $error("result changed while stalled");

	// Every error status closes its walk.
	a_err_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status != ST_OK) |-> last)
		else $error("error result not marked last");

	// An empty chain carries no disk range.
	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == ST_EMPTY) |-> (byte_offset == '0) && (byte_count == '0))
		else $error("empty chain result carries a range");

	// A walk item blocks the input while the geometry settles.
	a_walk_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && ((command == CMD_FILE) || (command == CMD_DIR)) |=> !in_ready)
		else $error("input ready right after a walk item");

endmodule

bind fat16_cluster_chain_walker fccw_checker u_checker (.*);

`default_nettype wire
